[rtl/seip_pkg.sv]
// shared types, widths and helpers for the 3x3 inverse power iteration core
// no dependencies; imported by every module of the block
package seip_pkg;

    localparam int VEC_FRAC_BITS = 30;
    localparam int TOL_SH        = 2 * VEC_FRAC_BITS;

    localparam int ENTRY_W    = 32;
    localparam int LIMB_W     = 32;
    localparam int OP_W       = LIMB_W + 1;
    localparam int PROD_W     = 2 * OP_W;
    localparam int WIDE_W     = 65;
    localparam int MAG_W      = 98;
    localparam int ACC_W      = 100;
    localparam int ROOT_W     = 64;
    localparam int SD_STEPS   = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 1'd1;

    localparam logic [7:0] MAX_ITER_RESET = 8'd100;

    typedef struct packed {
        logic signed [ENTRY_W-1:0] entry_00;
        logic signed [ENTRY_W-1:0] entry_01;
        logic signed [ENTRY_W-1:0] entry_02;
        logic signed [ENTRY_W-1:0] entry_10;
        logic signed [ENTRY_W-1:0] entry_11;
        logic signed [ENTRY_W-1:0] entry_12;
        logic signed [ENTRY_W-1:0] entry_20;
        logic signed [ENTRY_W-1:0] entry_21;
        logic signed [ENTRY_W-1:0] entry_22;
    } matrix_t;

    typedef struct packed {
        logic signed [31:0] vec_x;
        logic signed [31:0] vec_y;
        logic signed [31:0] vec_z;
        logic               singular;
        logic [7:0]         passes_used;
    } result_t;

    typedef struct packed {
        logic                   en;
        logic                   clr;
        logic                   neg;
        logic                   sh;
        logic signed [OP_W-1:0] a;
        logic signed [OP_W-1:0] b;
    } mac_cmd_t;

    typedef struct packed {
        logic        start_sqrt;
        logic        start_div;
        logic [63:0] operand;
    } sd_cmd_t;

    typedef struct packed {
        logic        done;
        logic [31:0] value;
    } sd_stat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MAC,
        ST_WAIT,
        ST_STORE,
        ST_NORM,
        ST_SQRT,
        ST_DIV,
        ST_CHECK,
        ST_OUT
    } state_t;

    typedef enum logic [2:0] {
        PH_COF,
        PH_DET,
        PH_Y,
        PH_SQ,
        PH_AX,
        PH_LAM
    } phase_t;

    // one 33 bit limb of a 65 bit signed word
    function automatic logic signed [OP_W-1:0] limb(input logic signed [WIDE_W-1:0] w,
                                                    input logic lo);
        logic signed [OP_W-1:0] r;
        if (lo)
            r = {1'b0, w[LIMB_W-1:0]};
        else
            r = w[WIDE_W-1:LIMB_W];
        return r;
    endfunction

    function automatic logic [1:0] inc3(input logic [1:0] v);
        return (v == 2'd2) ? 2'd0 : v + 2'd1;
    endfunction

    // flat index of row r, column c
    function automatic logic [3:0] idx3(input logic [1:0] r, input logic [1:0] c);
        return {r, 1'b0} + {2'b00, r} + {2'b00, c};
    endfunction

endpackage

[rtl/seip_mac.sv]
// shared signed multiply-accumulate unit: registered 33x33 product, then a
// wide accumulate with optional limb shift and subtract; uses seip_pkg
module seip_mac
    import seip_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  mac_cmd_t                cmd,
    output logic signed [ACC_W-1:0] acc
);

    logic signed [PROD_W-1:0] prod_reg;
    logic                     en_d_reg;
    logic                     clr_d_reg;
    logic                     neg_d_reg;
    logic                     sh_d_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W-1:0]  ext;
    logic signed [ACC_W-1:0]  term;
    logic signed [ACC_W-1:0]  base;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_d_reg <= 1'b0;
        end
        else
        begin
            en_d_reg <= cmd.en;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg  <= cmd.a * cmd.b;
        clr_d_reg <= cmd.clr;
        neg_d_reg <= cmd.neg;
        sh_d_reg  <= cmd.sh;
        acc_reg   <= acc_next;
    end

    always_comb
    begin
        ext  = ACC_W'(prod_reg);
        term = sh_d_reg ? (ext <<< LIMB_W) : ext;
        base = clr_d_reg ? '0 : acc_reg;
        if (!en_d_reg)
            acc_next = acc_reg;
        else if (neg_d_reg)
            acc_next = base - term;
        else
            acc_next = base + term;
    end

    assign acc = acc_reg;

endmodule

[rtl/seip_sqdiv.sv]
// iterative integer square root and restoring divider, one bit per cycle;
// the divisor is the root left by the last square root; uses seip_pkg
module seip_sqdiv
    import seip_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  sd_cmd_t  cmd,
    output sd_stat_t stat
);

    logic              busy_reg;
    logic              mode_reg;
    logic              done_reg;
    logic [4:0]        cnt_reg;
    logic [ROOT_W-1:0] rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [ROOT_W-1:0] bit_reg;
    logic [31:0]       prem_reg;
    logic [31:0]       dvd_reg;
    logic [31:0]       quot_reg;
    logic [ROOT_W-1:0] trial;
    logic              take_sq;
    logic [32:0]       cand;
    logic              take_dv;
    logic [63:0]       dvd_start;

    assign trial     = root_reg + bit_reg;
    assign take_sq   = rem_reg >= trial;
    assign cand      = {prem_reg, dvd_reg[31]};
    assign take_dv   = cand >= {1'b0, root_reg[31:0]};
    // add half the divisor so the quotient rounds half away from zero
    assign dvd_start = (cmd.operand << VEC_FRAC_BITS) + {33'd0, root_reg[31:1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            mode_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.start_sqrt || cmd.start_div)
            begin
                busy_reg <= 1'b1;
                mode_reg <= cmd.start_div;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'(SD_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start_sqrt)
        begin
            rem_reg  <= cmd.operand;
            root_reg <= '0;
            bit_reg  <= ROOT_W'(1) << (ROOT_W - 2);
        end
        else if (cmd.start_div)
        begin
            prem_reg <= dvd_start[63:32];
            dvd_reg  <= dvd_start[31:0];
            quot_reg <= '0;
        end
        else if (busy_reg && !mode_reg)
        begin
            if (take_sq)
            begin
                rem_reg  <= rem_reg - trial;
                root_reg <= (root_reg >> 1) + bit_reg;
            end
            else
            begin
                root_reg <= root_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
        else if (busy_reg)
        begin
            prem_reg <= take_dv ? 32'(cand - {1'b0, root_reg[31:0]}) : cand[31:0];
            dvd_reg  <= dvd_reg << 1;
            quot_reg <= {quot_reg[30:0], take_dv};
        end
    end

    assign stat.done  = done_reg;
    assign stat.value = mode_reg ? quot_reg : root_reg[31:0];

endmodule

[rtl/smallest_eigvec_inverse_power_3x3_core.sv]
// top level of the 3x3 smallest-eigenvalue eigenvector core
// depends on seip_pkg, seip_mac and seip_sqdiv
//
//  channel   signals                              direction  carries
//  cfg       cfg_we, cfg_index, cfg_data          in         max_iterations, tolerance
//  matrix    matrix_valid, matrix_ready, matrix   in         nine signed q16.16 entries
//  result    result_valid, result_ready, result   out        q2.30 vector, flags, passes
//
// one matrix at a time: cofactors and determinant first, then the passes, each
// with a length set by the serial root and the three bit-serial
// divisions on seip_sqdiv plus 36 products through the single seip_mac
// matrix_ready is high only while idle; the finished result waits in its
// output register so the next matrix can be taken before it is collected
// reset restores max_iterations to 100 and tolerance to 0
module smallest_eigvec_inverse_power_3x3_core
    import seip_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  matrix_valid,
    output logic                  matrix_ready,
    input  matrix_t               matrix,
    output logic                  result_valid,
    input  logic                  result_ready,
    output result_t               result
);

    // control state
    state_t     state_reg, state_next;
    phase_t     phase_reg, phase_next;
    logic [3:0] g_reg, g_next;
    logic [2:0] t_reg, t_next;
    logic       result_valid_reg;

    // configuration
    logic [7:0]  max_iter_reg;
    logic [31:0] tol_reg;

    // datapath storage
    logic signed [ENTRY_W-1:0] mat_a_reg [9];
    logic signed [ENTRY_W-1:0] mat_b_reg [9];
    logic signed [WIDE_W-1:0]  cof_reg [9];
    logic signed [WIDE_W-1:0]  ax_reg [3];
    logic signed [31:0]        x_reg [3];
    logic [MAG_W-1:0]          mag_reg [3];
    logic [2:0]                neg_reg;
    logic                      ndet_reg;
    logic                      sing_reg;
    logic [7:0]                passes_reg;
    logic signed [ACC_W-1:0]   prev_reg;
    logic signed [ACC_W-1:0]   diff_reg;
    result_t                   result_reg;

    logic signed [ENTRY_W-1:0] mat_in [9];

    // read ports
    logic [3:0] ai, bi, ci;
    logic [1:0] xi, axi, vi;
    logic signed [ENTRY_W-1:0] a_rd, b_rd;
    logic signed [WIDE_W-1:0]  c_rd, ax_rd;
    logic signed [31:0]        x_rd;
    logic [30:0]               v_rd;

    // cofactor row and column split
    logic [1:0] cr, cc;
    logic [1:0] cterm;

    mac_cmd_t                mac_cmd;
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] acc_abs;
    sd_cmd_t                 sd_cmd;
    sd_stat_t                sd_stat;

    logic [2:0]         last_t;
    logic [MAG_W-1:0]   mag_or;
    logic               norm_done;
    logic               vec_zero;
    logic [ACC_W-1:0]   diff_abs;
    logic [ACC_W-1:0]   tol_wide;
    logic [7:0]         limit;
    logic               go;
    logic signed [31:0] q_signed;

    assign mat_in[0] = matrix.entry_00;
    assign mat_in[1] = matrix.entry_01;
    assign mat_in[2] = matrix.entry_02;
    assign mat_in[3] = matrix.entry_10;
    assign mat_in[4] = matrix.entry_11;
    assign mat_in[5] = matrix.entry_12;
    assign mat_in[6] = matrix.entry_20;
    assign mat_in[7] = matrix.entry_21;
    assign mat_in[8] = matrix.entry_22;

    assign matrix_ready = (state_reg == ST_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_iter_reg <= MAX_ITER_RESET;
            tol_reg      <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MAX_ITER:  max_iter_reg <= cfg_data[7:0];
                REG_TOLERANCE: tol_reg      <= cfg_data;
                default:       ;
            endcase
        end
    end

    // cofactor (row, column) of the current group
    always_comb
    begin
        if (g_reg >= 4'd6)
            cr = 2'd2;
        else if (g_reg >= 4'd3)
            cr = 2'd1;
        else
            cr = 2'd0;
        cc = 2'(g_reg - {cr, 1'b0} - {2'b00, cr});
    end

    assign cterm = t_reg[2:1];

    // operand sequencing for the shared multiplier
    always_comb
    begin
        ai      = '0;
        bi      = '0;
        ci      = '0;
        xi      = '0;
        axi     = '0;
        last_t  = 3'd0;
        mac_cmd = '0;
        mac_cmd.en  = (state_reg == ST_MAC);
        mac_cmd.clr = (t_reg == 3'd0);
        unique case (phase_reg)
            PH_COF:
            begin
                // minor of (cr, cc) from the two following rows and columns
                last_t = 3'd1;
                if (t_reg[0])
                begin
                    ai = idx3(inc3(cr), inc3(inc3(cc)));
                    bi = idx3(inc3(inc3(cr)), inc3(cc));
                end
                else
                begin
                    ai = idx3(inc3(cr), inc3(cc));
                    bi = idx3(inc3(inc3(cr)), inc3(inc3(cc)));
                end
                mac_cmd.a   = OP_W'(a_rd);
                mac_cmd.b   = OP_W'(b_rd);
                mac_cmd.neg = t_reg[0];
            end
            PH_DET:
            begin
                last_t = 3'd5;
                ai = {2'b00, cterm};
                ci = {2'b00, cterm};
                mac_cmd.a  = OP_W'(a_rd);
                mac_cmd.b  = limb(c_rd, t_reg[0]);
                mac_cmd.sh = !t_reg[0];
            end
            PH_Y:
            begin
                // row i of adj(a) is column i of the cofactors
                last_t = 3'd5;
                ci = idx3(cterm, g_reg[1:0]);
                xi = cterm;
                mac_cmd.a   = limb(c_rd, t_reg[0]);
                mac_cmd.b   = OP_W'(x_rd);
                mac_cmd.sh  = !t_reg[0];
                mac_cmd.neg = ndet_reg;
            end
            PH_SQ:
            begin
                last_t = 3'd2;
                mac_cmd.a = {2'b00, v_rd};
                mac_cmd.b = {2'b00, v_rd};
            end
            PH_AX:
            begin
                last_t = 3'd2;
                ai = idx3(g_reg[1:0], t_reg[1:0]);
                xi = t_reg[1:0];
                mac_cmd.a = OP_W'(a_rd);
                mac_cmd.b = OP_W'(x_rd);
            end
            PH_LAM:
            begin
                last_t = 3'd5;
                xi  = cterm;
                axi = cterm;
                mac_cmd.a  = OP_W'(x_rd);
                mac_cmd.b  = limb(ax_rd, t_reg[0]);
                mac_cmd.sh = !t_reg[0];
            end
            default: ;
        endcase
    end

    // vector read: squares during the sum, then one component per division
    always_comb
    begin
        priority if (state_reg == ST_MAC && phase_reg == PH_SQ)
            vi = t_reg[1:0];
        else if (state_reg == ST_DIV)
            vi = inc3(g_reg[1:0]);
        else
            vi = 2'd0;
    end

    assign a_rd  = mat_a_reg[ai];
    assign b_rd  = mat_b_reg[bi];
    assign c_rd  = cof_reg[ci];
    assign x_rd  = x_reg[xi];
    assign ax_rd = ax_reg[axi];
    assign v_rd  = mag_reg[vi][30:0];

    seip_mac u_mac
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (mac_cmd),
        .acc   (acc)
    );

    seip_sqdiv u_sqdiv
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (sd_cmd),
        .stat  (sd_stat)
    );

    assign acc_abs = acc[ACC_W-1] ? -acc : acc;

    // common shift target: largest magnitude in [2^30, 2^31)
    assign mag_or    = mag_reg[0] | mag_reg[1] | mag_reg[2];
    assign vec_zero  = (mag_or == '0);
    assign norm_done = (mag_or[MAG_W-1:31] == '0) && mag_or[30];

    assign diff_abs = diff_reg[ACC_W-1] ? ACC_W'(-diff_reg) : ACC_W'(diff_reg);
    assign tol_wide = ACC_W'(tol_reg) << TOL_SH;
    assign limit    = (max_iter_reg == 8'd0) ? 8'd1 : max_iter_reg;
    assign go       = (passes_reg < limit) && (diff_abs > tol_wide);
    assign q_signed = neg_reg[g_reg[1:0]] ? -sd_stat.value : sd_stat.value;

    // sqrt / divide launches
    always_comb
    begin
        sd_cmd = '0;
        sd_cmd.operand = {33'd0, v_rd};
        if (state_reg == ST_STORE && phase_reg == PH_SQ)
        begin
            sd_cmd.start_sqrt = 1'b1;
            sd_cmd.operand    = acc[63:0];
        end
        else if (state_reg == ST_SQRT && sd_stat.done)
        begin
            sd_cmd.start_div = 1'b1;
        end
        else if (state_reg == ST_DIV && sd_stat.done && g_reg != 4'd2)
        begin
            sd_cmd.start_div = 1'b1;
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_COF;
            g_reg     <= '0;
            t_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            g_reg     <= g_next;
            t_reg     <= t_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        g_next     = g_reg;
        t_next     = t_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (matrix_valid)
                begin
                    state_next = ST_MAC;
                    phase_next = PH_COF;
                    g_next     = '0;
                    t_next     = '0;
                end
            end
            ST_MAC:
            begin
                if (t_reg == last_t)
                begin
                    t_next     = '0;
                    state_next = ST_WAIT;
                end
                else
                begin
                    t_next = t_reg + 3'd1;
                end
            end
            ST_WAIT:
            begin
                state_next = ST_STORE;
            end
            ST_STORE:
            begin
                unique case (phase_reg)
                    PH_COF:
                    begin
                        state_next = ST_MAC;
                        if (g_reg == 4'd8)
                        begin
                            phase_next = PH_DET;
                            g_next     = '0;
                        end
                        else
                        begin
                            g_next = g_reg + 4'd1;
                        end
                    end
                    PH_DET:
                    begin
                        if (acc == '0)
                        begin
                            state_next = ST_OUT;
                        end
                        else
                        begin
                            state_next = ST_MAC;
                            phase_next = PH_Y;
                            g_next     = '0;
                        end
                    end
                    PH_Y:
                    begin
                        if (g_reg == 4'd2)
                        begin
                            state_next = ST_NORM;
                        end
                        else
                        begin
                            state_next = ST_MAC;
                            g_next     = g_reg + 4'd1;
                        end
                    end
                    PH_SQ:
                    begin
                        state_next = ST_SQRT;
                    end
                    PH_AX:
                    begin
                        state_next = ST_MAC;
                        if (g_reg == 4'd2)
                        begin
                            phase_next = PH_LAM;
                            g_next     = '0;
                        end
                        else
                        begin
                            g_next = g_reg + 4'd1;
                        end
                    end
                    PH_LAM:
                    begin
                        state_next = ST_CHECK;
                    end
                    default: ;
                endcase
            end
            ST_NORM:
            begin
                priority if (vec_zero)
                begin
                    state_next = ST_MAC;
                    phase_next = PH_AX;
                    g_next     = '0;
                end
                else if (norm_done)
                begin
                    state_next = ST_MAC;
                    phase_next = PH_SQ;
                    g_next     = '0;
                end
                else
                begin
                    state_next = ST_NORM;
                end
            end
            ST_SQRT:
            begin
                if (sd_stat.done)
                begin
                    state_next = ST_DIV;
                    g_next     = '0;
                end
            end
            ST_DIV:
            begin
                if (sd_stat.done)
                begin
                    if (g_reg == 4'd2)
                    begin
                        state_next = ST_MAC;
                        phase_next = PH_AX;
                        g_next     = '0;
                    end
                    else
                    begin
                        g_next = g_reg + 4'd1;
                    end
                end
            end
            ST_CHECK:
            begin
                if (go)
                begin
                    state_next = ST_MAC;
                    phase_next = PH_Y;
                    g_next     = '0;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!result_valid_reg || result_ready)
                    state_next = ST_IDLE;
            end
            default: ;
        endcase
    end

    // result transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (state_reg == ST_OUT && (!result_valid_reg || result_ready))
            result_valid_reg <= 1'b1;
        else if (result_ready)
            result_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_OUT && (!result_valid_reg || result_ready))
        begin
            result_reg.vec_x       <= x_reg[0];
            result_reg.vec_y       <= x_reg[1];
            result_reg.vec_z       <= x_reg[2];
            result_reg.singular    <= sing_reg;
            result_reg.passes_used <= passes_reg;
        end
    end

    // datapath updates
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (matrix_valid)
                begin
                    for (int k = 0; k < 9; k++)
                    begin
                        mat_a_reg[k] <= mat_in[k];
                        mat_b_reg[k] <= mat_in[k];
                    end
                end
            end
            ST_STORE:
            begin
                unique case (phase_reg)
                    PH_COF:
                    begin
                        cof_reg[g_reg] <= acc[WIDE_W-1:0];
                    end
                    PH_DET:
                    begin
                        // no passes yet; a singular matrix gets a zero vector, any other all ones
                        passes_reg <= '0;
                        prev_reg   <= '0;
                        ndet_reg   <= acc[ACC_W-1];
                        sing_reg   <= (acc == '0);
                        for (int k = 0; k < 3; k++)
                        begin
                            x_reg[k] <= (acc == '0) ? 32'sd0 : (32'sd1 <<< VEC_FRAC_BITS);
                        end
                    end
                    PH_Y:
                    begin
                        mag_reg[g_reg[1:0]] <= acc_abs[MAG_W-1:0];
                        neg_reg[g_reg[1:0]] <= acc[ACC_W-1];
                    end
                    PH_AX:
                    begin
                        ax_reg[g_reg[1:0]] <= acc[WIDE_W-1:0];
                    end
                    PH_LAM:
                    begin
                        diff_reg   <= acc - prev_reg;
                        prev_reg   <= acc;
                        passes_reg <= passes_reg + 8'd1;
                    end
                    default: ;
                endcase
            end
            ST_NORM:
            begin
                // coarse then fine steps toward the target bit
                if (vec_zero)
                begin
                    for (int k = 0; k < 3; k++)
                        x_reg[k] <= '0;
                end
                else if (!norm_done)
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        priority if (mag_or[MAG_W-1:39] != '0)
                            mag_reg[k] <= mag_reg[k] >> 8;
                        else if (mag_or[MAG_W-1:31] != '0)
                            mag_reg[k] <= mag_reg[k] >> 1;
                        else if (mag_or[30:23] == '0)
                            mag_reg[k] <= mag_reg[k] << 8;
                        else
                            mag_reg[k] <= mag_reg[k] << 1;
                    end
                end
            end
            ST_DIV:
            begin
                if (sd_stat.done)
                    x_reg[g_reg[1:0]] <= q_signed;
            end
            default: ;
        endcase
    end

endmodule
